// ----- hdl/fpec_pkg.sv -----
`timescale 1ns / 1ps
package fpec_pkg;
  localparam int FRAC_BITS = 16;
  localparam int PLANE_COUNT = 6;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    OP_LOAD_P = 3'd0,
    OP_LOAD_V = 3'd1,
    OP_EXTRACT = 3'd2,
    OP_BOX = 3'd3,
    OP_SPHERE = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAT_RD,
    ST_MAT_MUL,
    ST_MAT_ACC,
    ST_MAT_WR,
    ST_PL_RD,
    ST_PL_FORM,
    ST_PL_SQ,
    ST_PL_SQACC,
    ST_PL_SQRT,
    ST_PL_DIV,
    ST_PL_WR,
    ST_T_RD,
    ST_T_MUL,
    ST_T_ACC,
    ST_T_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_p;
    logic load_v;
    logic capture;
    logic clr_acc;
    logic mat_rd;
    logic mat_mul;
    logic mat_acc;
    logic mat_wr;
    logic pl_rd;
    logic pl_form;
    logic pl_sq;
    logic pl_sqacc;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic pl_wr;
    logic t_rd;
    logic t_mul;
    logic t_acc;
    logic t_chk;
    logic out_load;
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] k;
    logic [2:0] plane;
  } fpec_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic reject;
  } fpec_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(SAT_MAX)) return SAT_MAX;
    if (v < 66'(SAT_MIN)) return SAT_MIN;
    return v[31:0];
  endfunction
endpackage

// ----- hdl/fpec_if.sv -----
`timescale 1ns / 1ps
interface fpec_in_if;
  logic valid;
  logic ready;
  logic [2:0] op;
  logic [3:0] elem_index;
  logic signed [31:0] elem_value;
  logic signed [31:0] lo_x;
  logic signed [31:0] lo_y;
  logic signed [31:0] lo_z;
  logic signed [31:0] hi_x;
  logic signed [31:0] hi_y;
  logic signed [31:0] hi_z;
  logic [30:0] radius;
  modport source(output valid, op, elem_index, elem_value, lo_x, lo_y, lo_z, hi_x, hi_y,
    hi_z, radius, input ready);
  modport sink(input valid, op, elem_index, elem_value, lo_x, lo_y, lo_z, hi_x, hi_y,
    hi_z, radius, output ready);
endinterface

interface fpec_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic degenerate;
  modport source(output valid, visible, degenerate, input ready);
  modport sink(input valid, visible, degenerate, output ready);
endinterface

// ----- hdl/fpec_ctrl.sv -----
`timescale 1ns / 1ps
module fpec_ctrl
  import fpec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] in_op,
  output logic out_valid,
  input  logic out_ready,
  input  fpec_sts_t sts,
  output fpec_cmd_t cmd
);
  state_t state, state_next;
  logic [1:0] r, c, k;
  logic [2:0] plane;
  logic [1:0] comp;
  logic [1:0] r_next, c_next, k_next, comp_next;
  logic [2:0] plane_next;
  logic out_valid_next;
  logic accept;

  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      r <= '0;
      c <= '0;
      k <= '0;
      plane <= '0;
      comp <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      r <= r_next;
      c <= c_next;
      k <= k_next;
      plane <= plane_next;
      comp <= comp_next;
    end
  end

  always_comb begin
    state_next = state;
    r_next = r;
    c_next = c;
    k_next = k;
    plane_next = plane;
    comp_next = comp;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          r_next = '0;
          c_next = '0;
          k_next = '0;
          plane_next = '0;
          comp_next = '0;
          case (in_op)
            OP_EXTRACT: state_next = ST_MAT_RD;
            OP_BOX, OP_SPHERE: state_next = ST_T_RD;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_MAT_RD: state_next = ST_MAT_MUL;
      ST_MAT_MUL: state_next = ST_MAT_ACC;
      ST_MAT_ACC: begin
        k_next = k + 2'd1;
        state_next = (k == 2'd3) ? ST_MAT_WR : ST_MAT_RD;
      end
      ST_MAT_WR: begin
        c_next = c + 2'd1;
        if (c == 2'd3) r_next = r + 2'd1;
        state_next = (r == 2'd3 && c == 2'd3) ? ST_PL_RD : ST_MAT_RD;
      end
      ST_PL_RD: state_next = ST_PL_FORM;
      ST_PL_FORM: begin
        comp_next = comp + 2'd1;
        state_next = (comp == 2'd3) ? ST_PL_SQ : ST_PL_RD;
      end
      ST_PL_SQ: state_next = ST_PL_SQACC;
      ST_PL_SQACC: begin
        comp_next = comp + 2'd1;
        state_next = (comp == 2'd2) ? ST_PL_SQRT : ST_PL_SQ;
        if (comp == 2'd2) comp_next = '0;
      end
      ST_PL_SQRT: if (sts.sqrt_done) state_next = ST_PL_DIV;
      ST_PL_DIV: if (sts.div_done) state_next = ST_PL_WR;
      ST_PL_WR: begin
        comp_next = comp + 2'd1;
        if (comp == 2'd3) begin
          plane_next = plane + 3'd1;
          state_next = (plane == 3'(PLANE_COUNT - 1)) ? ST_DONE : ST_PL_RD;
        end else begin
          state_next = ST_PL_DIV;
        end
      end
      ST_T_RD: state_next = ST_T_MUL;
      ST_T_MUL: state_next = ST_T_ACC;
      ST_T_ACC: begin
        comp_next = comp + 2'd1;
        state_next = (comp == 2'd2) ? ST_T_CHK : ST_T_RD;
      end
      ST_T_CHK: begin
        comp_next = '0;
        plane_next = plane + 3'd1;
        state_next = (sts.reject || plane == 3'(PLANE_COUNT - 1)) ? ST_DONE : ST_T_RD;
      end
      ST_DONE: begin
        out_valid_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.r = r;
    cmd.c = c;
    cmd.k = k;
    cmd.plane = plane;
    case (state)
      ST_IDLE: begin
        cmd.capture = accept;
        cmd.clr_acc = accept;
        cmd.load_p = accept && in_op == OP_LOAD_P;
        cmd.load_v = accept && in_op == OP_LOAD_V;
      end
      ST_MAT_RD: begin
        cmd.mat_rd = 1'b1;
        cmd.k = k;
      end
      ST_MAT_MUL: cmd.mat_mul = 1'b1;
      ST_MAT_ACC: cmd.mat_acc = 1'b1;
      ST_MAT_WR: cmd.mat_wr = 1'b1;
      ST_PL_RD: begin
        cmd.pl_rd = 1'b1;
        cmd.c = comp;
      end
      ST_PL_FORM: begin
        cmd.pl_form = 1'b1;
        cmd.c = comp;
      end
      ST_PL_SQ: begin
        cmd.pl_sq = 1'b1;
        cmd.c = comp;
      end
      ST_PL_SQACC: begin
        cmd.pl_sqacc = 1'b1;
        cmd.sqrt_start = comp == 2'd2;
      end
      ST_PL_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.div_start = sts.sqrt_done;
        cmd.c = comp;
      end
      ST_PL_DIV: begin
        cmd.div_step = 1'b1;
        cmd.c = comp;
      end
      ST_PL_WR: begin
        cmd.pl_wr = 1'b1;
        cmd.c = comp;
        cmd.div_start = comp != 2'd3;
      end
      ST_T_RD: begin
        cmd.t_rd = 1'b1;
        cmd.c = comp;
        cmd.clr_acc = comp == 2'd0;
      end
      ST_T_MUL: begin
        cmd.t_mul = 1'b1;
        cmd.c = comp;
      end
      ST_T_ACC: begin
        cmd.t_acc = 1'b1;
        cmd.c = comp;
      end
      ST_T_CHK: cmd.t_chk = 1'b1;
      ST_DONE: cmd.out_load = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

// ----- hdl/fpec_dp.sv -----
`timescale 1ns / 1ps
module fpec_dp
  import fpec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  fpec_cmd_t cmd,
  input  logic [2:0] in_op,
  input  logic [3:0] elem_index,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] lo_x,
  input  logic signed [31:0] lo_y,
  input  logic signed [31:0] lo_z,
  input  logic signed [31:0] hi_x,
  input  logic signed [31:0] hi_y,
  input  logic signed [31:0] hi_z,
  input  logic [30:0] radius,
  output fpec_sts_t sts,
  output logic visible,
  output logic degenerate
);
  logic signed [31:0] proj_matrix [16];
  logic signed [31:0] view_matrix [16];
  logic signed [31:0] m_store [16];
  logic signed [31:0] plane_store [24];
  logic [23:0] plane_valid;

  logic [2:0] op;
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic [30:0] rad;

  logic signed [31:0] opa, opb;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [65:0] acc;
  logic signed [31:0] p_raw [4];
  logic signed [31:0] ma, mb;
  logic [64:0] sq_acc;
  logic degen;
  logic vis;

  logic [1:0] row;
  logic [4:0] pidx;
  logic signed [31:0] pl_rd_val;

  // sqrt unit
  logic [63:0] s_rem, s_res, s_bit;
  logic sqrt_busy;
  logic [31:0] len;
  // divider
  logic [79:0] d_num;
  logic [47:0] d_rem;
  logic [63:0] d_q;
  logic [6:0] d_cnt;
  logic d_busy;
  logic [48:0] d_trial;
  logic signed [31:0] q_res;
  logic [1:0] div_idx;

  assign row = 2'(cmd.plane >> 1);
  assign pidx = 5'({cmd.plane, 2'b00}) + 5'(cmd.c);
  assign pl_rd_val = plane_valid[pidx] ? plane_store[pidx] : '0;

  // the shared multiplier squares the raw plane components directly
  assign mul_a = cmd.pl_sq ? p_raw[cmd.c] : opa;
  assign mul_b = cmd.pl_sq ? p_raw[cmd.c] : opb;

  always_ff @(posedge clk) begin
    if (cmd.load_p) proj_matrix[elem_index] <= elem_value;
    if (cmd.load_v) view_matrix[elem_index] <= elem_value;
    if (cmd.capture) begin
      op <= in_op;
      lo[0] <= lo_x;
      lo[1] <= lo_y;
      lo[2] <= lo_z;
      hi[0] <= hi_x;
      hi[1] <= hi_y;
      hi[2] <= hi_z;
      rad <= radius;
      degen <= 1'b0;
      vis <= 1'b1;
    end
    if (cmd.clr_acc) acc <= '0;
    if (cmd.mat_rd) begin
      opa <= proj_matrix[{cmd.r, cmd.k}];
      opb <= view_matrix[{cmd.k, cmd.c}];
    end
    if (cmd.mat_mul || cmd.t_mul || cmd.pl_sq) prod <= mul_a * mul_b;
    if (cmd.mat_acc) acc <= acc + 66'(prod >>> FRAC_BITS);
    if (cmd.mat_wr) begin
      m_store[{cmd.r, cmd.c}] <= sat32(acc);
      acc <= '0;
    end
    if (cmd.pl_rd) begin
      ma <= m_store[{2'd3, cmd.c}];
      mb <= m_store[{row, cmd.c}];
    end
    if (cmd.pl_form) begin
      p_raw[cmd.c] <= cmd.plane[0] ? sat32(66'(ma) - 66'(mb)) : sat32(66'(ma) + 66'(mb));
      if (cmd.c == 2'd3) sq_acc <= '0;
    end
    if (cmd.pl_sqacc) sq_acc <= sq_acc + 65'(unsigned'(prod));
    if (cmd.pl_wr && len == 0) degen <= 1'b1;
    if (cmd.t_rd) begin
      opa <= pl_rd_val;
      if (op == OP_BOX) opb <= pl_rd_val[31] ? lo[cmd.c] : hi[cmd.c];
      else opb <= lo[cmd.c];
    end
    if (cmd.t_acc) acc <= acc + 66'(prod >>> FRAC_BITS);
    if (cmd.t_chk) begin
      if (sts.reject) vis <= 1'b0;
    end
  end

  // sqrt: one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sqrt_busy <= 1'b1;
      s_rem <= sq_acc[63:0] + 64'(prod);
      s_res <= '0;
      s_bit <= 64'h4000000000000000;
    end else if (cmd.sqrt_step && sqrt_busy) begin
      if (s_bit == 0) begin
        sqrt_busy <= 1'b0;
        len <= s_res[31:0];
      end else begin
        if (s_rem >= s_res + s_bit) begin
          s_rem <= s_rem - (s_res + s_bit);
          s_res <= (s_res >> 1) + s_bit;
        end else begin
          s_res <= s_res >> 1;
        end
        s_bit <= s_bit >> 2;
      end
    end
  end
  assign sts.sqrt_done = sqrt_busy && cmd.sqrt_step && s_bit == 0;

  // restoring divider, one quotient bit per cycle
  // a division started on a write takes the next component
  logic [31:0] mag;
  assign div_idx = cmd.pl_wr ? cmd.c + 2'd1 : cmd.c;
  assign mag = p_raw[div_idx][31] ? 32'(-p_raw[div_idx]) : p_raw[div_idx];
  assign d_trial = {d_rem, d_num[79]} - {17'd0, len};
  always_ff @(posedge clk) begin
    if (rst) begin
      d_busy <= 1'b0;
    end else if (cmd.div_start) begin
      d_busy <= 1'b1;
      d_num <= 80'(mag) << (FRAC_BITS + 32);
      d_rem <= '0;
      d_q <= '0;
      d_cnt <= 7'd48;
    end else if (cmd.div_step && d_busy) begin
      if (d_cnt == 0) begin
        d_busy <= 1'b0;
      end else begin
        d_num <= d_num << 1;
        d_cnt <= d_cnt - 7'd1;
        if (!d_trial[48]) begin
          d_rem <= d_trial[47:0];
          d_q <= {d_q[62:0], 1'b1};
        end else begin
          d_rem <= {d_rem[46:0], d_num[79]};
          d_q <= {d_q[62:0], 1'b0};
        end
      end
    end
  end
  assign sts.div_done = d_busy && cmd.div_step && d_cnt == 0;
  assign q_res = (len == 0) ? '0 : (p_raw[cmd.c][31] ? sat32(-66'(d_q)) : sat32(66'(d_q)));

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_valid <= '0;
    end else if (cmd.pl_wr) begin
      plane_valid[pidx] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.pl_wr) begin
      plane_store[pidx] <= q_res;
    end
  end

  logic signed [65:0] pl_dist;
  assign pl_dist = acc + 66'(plane_valid[{cmd.plane, 2'd3}] ? plane_store[{cmd.plane, 2'd3}] : 32'sd0);
  assign sts.reject = (op == OP_BOX) ? (pl_dist <= 0) : (pl_dist < -$signed(66'(rad)));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      visible <= (op == OP_BOX || op == OP_SPHERE) ? vis : 1'b0;
      degenerate <= (op == OP_EXTRACT) ? degen : 1'b0;
    end
  end
endmodule

// ----- hdl/frustum_plane_extract_and_cull.sv -----
`timescale 1ns / 1ps
// frustum plane extraction and culling
// channels: in (op, matrix element, box or sphere) and out (visible, degenerate)
// every accepted transaction yields exactly one output transaction
// loads and spare ops go straight to the result; a box or sphere test walks the
// planes on the shared multiply-accumulate, ending at the first rejecting plane
// extract computes P*V (16 elements), then per plane forming and squaring, a
// square root and four divide-and-store steps
// one transaction is in work at a time; in.ready is low while busy or while
// a result waits on out, so the next transaction is taken in the cycle after
// the result is taken, at the earliest
// reset (rst, synchronous) clears the controller and the plane store
// a stalled receiver holds the result and the block accepts nothing more
// matrix elements not yet loaded read as undefined
module frustum_plane_extract_and_cull
  import fpec_pkg::*;
(
  input logic clk,
  input logic rst,
  fpec_in_if.sink in,
  fpec_out_if.source out
);
  fpec_cmd_t cmd;
  fpec_sts_t sts;

  fpec_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready), .in_op(in.op),
    .out_valid(out.valid), .out_ready(out.ready),
    .sts(sts), .cmd(cmd)
  );

  fpec_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_op(in.op),
    .elem_index(in.elem_index), .elem_value(in.elem_value),
    .lo_x(in.lo_x), .lo_y(in.lo_y), .lo_z(in.lo_z),
    .hi_x(in.hi_x), .hi_y(in.hi_y), .hi_z(in.hi_z),
    .radius(in.radius), .sts(sts),
    .visible(out.visible), .degenerate(out.degenerate)
  );
endmodule

// ----- hdl/fpec_checker.sv -----
`timescale 1ns / 1ps
module fpec_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic visible,
  input logic degenerate
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(degenerate))
    else $error("result changed under stall");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(visible && degenerate) || !out_valid)
    else $error("both flags set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_valid |-> !in_ready)
    else $error("accepted while result pending");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind frustum_plane_extract_and_cull fpec_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .visible(out.visible), .degenerate(out.degenerate)
);
